// ===== rtl/i2ctrm_pkg.sv =====
package i2ctrm_pkg;

	// event codes
	typedef enum logic [1:0] {
		OP_START     = 2'd0,
		OP_SHIFT     = 2'd1,
		OP_REG_WRITE = 2'd2,
		OP_ARM_RX    = 2'd3
	} opcode_t;

	// shift register load codes
	localparam logic [1:0] LOAD_KEEP = 2'd0;
	localparam logic [1:0] LOAD_ACK  = 2'd1;
	localparam logic [1:0] LOAD_NACK = 2'd2;
	localparam logic [1:0] LOAD_TX   = 2'd3;

	// host status codes
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_BAD  = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	// byte phases, one-hot
	typedef enum logic [7:0] {
		PH_CHECK_ADDR  = 8'b0000_0001,
		PH_SEND        = 8'b0000_0010,
		PH_REQ_REPLY   = 8'b0000_0100,
		PH_CHECK_REPLY = 8'b0000_1000,
		PH_REQ_DATA    = 8'b0001_0000,
		PH_GET_DATA    = 8'b0010_0000,
		PH_NACK        = 8'b0100_0000,
		PH_NACKED      = 8'b1000_0000
	} phase_t;

	typedef struct packed {
		logic [1:0] opcode;
		logic [7:0] bus_byte;
		logic [7:0] reg_offset;
		logic [7:0] reg_value;
		logic [7:0] receive_length;
	} in_word_t;

	typedef struct packed {
		logic       sda_drive;
		logic [1:0] shift_load;
		logic [7:0] tx_byte;
		logic       one_bit_phase;
		logic       await_start;
		logic       rx_valid;
		logic [7:0] rx_byte;
		logic       rx_done;
		logic       rx_aborted;
		logic [1:0] host_status;
	} out_word_t;

endpackage

// ===== rtl/i2ctrm_if.sv =====
interface i2ctrm_in_if;
	import i2ctrm_pkg::*;
	logic     valid;
	logic     ready;
	in_word_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface i2ctrm_out_if;
	import i2ctrm_pkg::*;
	logic      valid;
	logic      ready;
	out_word_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/i2ctrm_queue.sv =====
module i2ctrm_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  i2ctrm_pkg::in_word_t  push_word,
	output logic                  full,
	input  logic                  pop,
	output i2ctrm_pkg::in_word_t  pop_word,
	output logic                  not_empty
);
	import i2ctrm_pkg::*;

	// two-entry word queue between front and back
	in_word_t   mem_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;

	assign full      = cnt_q[1];
	assign not_empty = (cnt_q != 2'd0);
	assign pop_word  = mem_q[rp_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= push_word;
	end

	// pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end
endmodule

// ===== rtl/i2ctrm_engine.sv =====
module i2ctrm_engine #(
	parameter int REG_COUNT      = 16,
	parameter int RX_QUEUE_DEPTH = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [7:0]            own_address,
	input  logic                  go,
	input  i2ctrm_pkg::in_word_t  word,
	output i2ctrm_pkg::out_word_t result
);
	import i2ctrm_pkg::*;

	localparam int RW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
	localparam int QW = (RX_QUEUE_DEPTH > 1) ? $clog2(RX_QUEUE_DEPTH) : 1;
	localparam int UW = $clog2(RX_QUEUE_DEPTH + 1);

	logic [7:0]    regs_q [REG_COUNT];
	logic [REG_COUNT-1:0] reg_ok_q;
	logic [7:0]    lens_q [RX_QUEUE_DEPTH];
	phase_t        phase_q;
	logic [RW-1:0] send_q;
	logic [7:0]    rcvd_q;
	logic          active_q;
	logic [7:0]    alen_q;
	logic [QW-1:0] head_q;
	logic [UW-1:0] used_q;

	phase_t        ph_n;
	logic [RW-1:0] send_n;
	logic [7:0]    rcvd_n;
	logic          active_n;
	logic [7:0]    alen_n;
	logic [QW-1:0] head_n;
	logic [UW-1:0] used_n;
	logic          pop_len;
	logic          push_len;
	logic          wr_reg;
	logic [QW-1:0] tail;
	logic [8:0]    tail_sum;
	out_word_t     r;
	logic [7:0]    send_byte;

	// head plus fill is below twice the depth, one subtract wraps it
	assign tail_sum = 9'(head_q) + 9'(used_q);
	assign tail = (32'(tail_sum) >= RX_QUEUE_DEPTH) ?
		QW'(tail_sum - 9'(RX_QUEUE_DEPTH)) : QW'(tail_sum);
	assign send_byte = reg_ok_q[send_q] ? regs_q[send_q] : 8'h00;

	function automatic logic [QW-1:0] q_inc(input logic [QW-1:0] v);
		return (32'(v) == RX_QUEUE_DEPTH - 1) ? '0 : v + QW'(1);
	endfunction

	function automatic logic [RW-1:0] r_inc(input logic [RW-1:0] v);
		return (32'(v) == REG_COUNT - 1) ? '0 : v + RW'(1);
	endfunction

	// per-event next state and result word
	always_comb begin
		ph_n = phase_q; send_n = send_q; rcvd_n = rcvd_q; active_n = active_q;
		alen_n = alen_q; head_n = head_q; used_n = used_q;
		pop_len = 1'b0; push_len = 1'b0; wr_reg = 1'b0;
		r = '0;
		unique case (opcode_t'(word.opcode))
			OP_START: begin
				if (active_q) begin
					active_n = 1'b0;
					r.rx_aborted = 1'b1;
				end
				ph_n = PH_CHECK_ADDR;
			end
			OP_SHIFT: begin
				unique case (phase_q)
					PH_CHECK_ADDR: begin
						if (word.bus_byte == 8'h00 ||
							word.bus_byte[7:1] == own_address[7:1]) begin
							send_n = '0;
							rcvd_n = '0;
							if (word.bus_byte[0]) ph_n = PH_SEND;
							else if (used_q != '0) begin
								pop_len  = 1'b1;
								alen_n   = lens_q[head_q];
								head_n   = q_inc(head_q);
								used_n   = used_q - UW'(1);
								active_n = 1'b1;
								ph_n     = PH_REQ_DATA;
							end else ph_n = PH_NACK;
						end
					end
					PH_REQ_DATA: ph_n = PH_GET_DATA;
					PH_GET_DATA: begin
						if (!active_q) ph_n = PH_NACK;
						else begin
							if (rcvd_q < alen_q) begin
								r.rx_valid = 1'b1;
								r.rx_byte  = word.bus_byte;
								rcvd_n     = rcvd_q + 8'd1;
							end
							if (rcvd_n < alen_q) ph_n = PH_REQ_DATA;
							else begin
								r.rx_done = 1'b1;
								active_n  = 1'b0;
								ph_n      = PH_NACK;
							end
						end
					end
					PH_REQ_REPLY: ph_n = PH_CHECK_REPLY;
					PH_CHECK_REPLY: begin
						if (word.bus_byte != 8'h00) ph_n = PH_CHECK_ADDR;
						else begin
							r.tx_byte = send_byte;
							send_n    = r_inc(send_q);
							ph_n      = PH_REQ_REPLY;
						end
					end
					PH_SEND: begin
						r.tx_byte = send_byte;
						send_n    = r_inc(send_q);
						ph_n      = PH_REQ_REPLY;
					end
					PH_NACK: ph_n = PH_NACKED;
					PH_NACKED: ph_n = PH_NACKED;
					default: ph_n = PH_NACKED;
				endcase
				// bus outputs from the new phase
				unique case (ph_n)
					PH_CHECK_ADDR, PH_NACKED: r.await_start = 1'b1;
					PH_SEND, PH_REQ_DATA: begin
						r.sda_drive = 1'b1; r.shift_load = LOAD_ACK; r.one_bit_phase = 1'b1;
					end
					PH_REQ_REPLY: begin
						r.sda_drive = 1'b1; r.shift_load = LOAD_TX;
					end
					PH_CHECK_REPLY: begin
						r.shift_load = LOAD_ACK; r.one_bit_phase = 1'b1;
					end
					PH_GET_DATA: r.shift_load = LOAD_KEEP;
					default: begin
						r.sda_drive = 1'b1; r.shift_load = LOAD_NACK; r.one_bit_phase = 1'b1;
					end
				endcase
				if (r.shift_load != LOAD_TX) r.tx_byte = 8'h00;
			end
			OP_REG_WRITE: begin
				if (32'(word.reg_offset) >= REG_COUNT) r.host_status = ST_BAD;
				else wr_reg = 1'b1;
			end
			default: begin
				if (word.receive_length == 8'h00) r.host_status = ST_BAD;
				else if (32'(used_q) >= RX_QUEUE_DEPTH) r.host_status = ST_FULL;
				else begin
					push_len = 1'b1;
					used_n   = used_q + UW'(1);
				end
			end
		endcase
		if (pop_len) used_n = used_q - UW'(1);
	end

	assign result = r;

	// register file and length queue storage
	always_ff @(posedge clk) begin
		if (go && wr_reg) regs_q[word.reg_offset[RW-1:0]] <= word.reg_value;
		if (go && push_len) lens_q[tail] <= word.receive_length;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reg_ok_q <= '0;
			phase_q  <= PH_CHECK_ADDR;
			send_q   <= '0;
			rcvd_q   <= '0;
			active_q <= 1'b0;
			alen_q   <= '0;
			head_q   <= '0;
			used_q   <= '0;
		end else if (go) begin
			if (wr_reg) reg_ok_q[word.reg_offset[RW-1:0]] <= 1'b1;
			phase_q  <= ph_n;
			send_q   <= send_n;
			rcvd_q   <= rcvd_n;
			active_q <= active_n;
			alen_q   <= alen_n;
			head_q   <= head_n;
			used_q   <= used_n;
		end
	end
endmodule

// ===== rtl/i2c_target_register_mailbox.sv =====
// channel | dir | payload      | accepted at
// in_ch   | in  | in_word_t    | valid && ready
// out_ch  | out | out_word_t   | valid && ready
// cfg     | in  | own_address  | cfg_we
// each word is accepted into a two-entry queue; the back end executes one
// word per cycle while the output is not stalled, and its result is
// registered in the output register.
// reset clears state, marks every register unwritten (it reads as zero) and empties the receive queue.
// a stalled output holds the back end; the queue then fills and drops ready.
module i2c_target_register_mailbox #(
	parameter int REG_COUNT      = 16,
	parameter int RX_QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	i2ctrm_in_if.sink   in_ch,
	i2ctrm_out_if.source out_ch
);
	import i2ctrm_pkg::*;

	logic [7:0] own_addr_q;
	logic       q_full;
	logic       q_ne;
	logic       go;
	in_word_t   q_word;
	out_word_t  res;
	out_word_t  out_s2;
	logic       out_v_q;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) own_addr_q <= 8'h00;
		else if (cfg_we) own_addr_q <= cfg_wdata;
	end

	// front queue
	assign in_ch.ready = ~q_full;
	assign go = q_ne && (!out_v_q || out_ch.ready);

	i2ctrm_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.push(in_ch.valid && !q_full), .push_word(in_ch.payload), .full(q_full),
		.pop(go), .pop_word(q_word), .not_empty(q_ne)
	);

	// back end
	i2ctrm_engine #(.REG_COUNT(REG_COUNT), .RX_QUEUE_DEPTH(RX_QUEUE_DEPTH)) u_engine (
		.clk(clk), .arst_n(arst_n), .own_address(own_addr_q),
		.go(go), .word(q_word), .result(res)
	);

	// output register
	always_ff @(posedge clk) begin
		if (go) out_s2 <= res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_v_q <= 1'b0;
		else if (go) out_v_q <= 1'b1;
		else if (out_ch.ready) out_v_q <= 1'b0;
	end

	assign out_ch.valid   = out_v_q;
	assign out_ch.payload = out_s2;
endmodule

// ===== rtl/i2ctrm_checker.sv =====
module i2ctrm_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] out_load,
	input logic [7:0] out_tx,
	input logic       out_rxv,
	input logic [7:0] out_rxb
);
	import i2ctrm_pkg::*;

	// tx byte only with a load of tx
	a_tx: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_load != LOAD_TX |-> out_tx == 8'h00) else $error("tx leak");
	// rx byte zero when not valid
	a_rx: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_rxv |-> out_rxb == 8'h00) else $error("rx leak");
	// stalled output holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("output dropped");
	// accepted word passes the queue and the output register when output free
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !out_valid |=> ##1 out_valid) else $error("word lost");
endmodule

bind i2c_target_register_mailbox i2ctrm_checker u_chk (
	.clk(clk), .arst_n(arst_n),
	.in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.out_load(out_ch.payload.shift_load), .out_tx(out_ch.payload.tx_byte),
	.out_rxv(out_ch.payload.rx_valid), .out_rxb(out_ch.payload.rx_byte)
);
